FILE: rtl/core/srecord_data_line_parser_unit_assert.svh
// Assertion macros shared by the S-record line parser RTL.
`ifndef SRECORD_DATA_LINE_PARSER_UNIT_ASSERT_SVH
`define SRECORD_DATA_LINE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SRDLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SRDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SRDLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SRDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/srdlp_pkg.sv
// Shared types, codes and the hex digit decoder of the S-record line parser.
`default_nettype none
package srdlp_pkg;

	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_S_UP  = 8'h53;
	localparam logic [7:0] CHAR_S_LOW = 8'h73;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_THREE = 8'h33;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A_UP  = 8'h41;
	localparam logic [7:0] CHAR_F_UP  = 8'h46;
	localparam logic [7:0] CHAR_A_LOW = 8'h61;
	localparam logic [7:0] CHAR_F_LOW = 8'h66;

	localparam int POS_W = 10;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
	localparam logic [1:0] STAT_IGNORED   = 2'd1;
	localparam logic [1:0] STAT_BAD_SUM   = 2'd2;
	localparam logic [1:0] STAT_MALFORMED = 2'd3;

	localparam logic [1:0] REC_NONE = 2'd0;

	typedef struct packed {
		logic       invalid;
		logic [3:0] value;
	} hex_digit_t;

	// One accepted character waiting in the input stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] character;
	} char_stage_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] address;
		logic [7:0]  data_byte;
		logic [7:0]  byte_offset;
		logic [1:0]  record_kind;
		logic [1:0]  line_status;
		logic [7:0]  data_length;
	} result_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] ch);
		hex_digit_t d;
		d.invalid = 1'b0;
		d.value   = 4'd0;
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			d.value = ch[3:0];
		end else if ((ch >= CHAR_A_UP && ch <= CHAR_F_UP) ||
			(ch >= CHAR_A_LOW && ch <= CHAR_F_LOW)) begin
			// Letters A-F and a-f share their low nibble 1..6.
			d.value = ch[3:0] + 4'd9;
		end else begin
			d.invalid = 1'b1;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/srdlp_stream_if.sv
// Valid/ready stream interfaces for characters in and parser results out.
`default_nettype none
interface srdlp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface srdlp_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic [7:0]  byte_offset;
	logic [1:0]  record_kind;
	logic [1:0]  line_status;
	logic [7:0]  data_length;

	modport source (output valid, output kind, output address, output data_byte,
		output byte_offset, output record_kind, output line_status,
		output data_length, input ready);
	modport sink (input valid, input kind, input address, input data_byte,
		input byte_offset, input record_kind, input line_status,
		input data_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/srdlp_in_stage.sv
// Input register stage that holds one accepted character.
`default_nettype none
module srdlp_in_stage (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire  [7:0]                in_char,
	output logic                      in_ready,
	input  wire                       advance,
	output srdlp_pkg::char_stage_t    stage
);
	import srdlp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;

	// The stage refills in the same cycle that its word moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
		end
	end

	assign stage.valid     = valid_s1;
	assign stage.character = char_s1;
endmodule
`default_nettype wire

FILE: rtl/core/srdlp_line_core.sv
// Per-line parse state and the combinational step that forms one result.
`default_nettype none
module srdlp_line_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  srdlp_pkg::char_stage_t    stage,
	input  wire                       advance,
	output logic                      res_valid,
	output srdlp_pkg::result_t        res
);
	import srdlp_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [1:0]       type_q, type_n;
	logic [3:0]       nib_q, nib_n;
	logic             nib_inv_q, nib_inv_n;
	logic [7:0]       count_q, count_n;
	logic [7:0]       sum_q, sum_n;
	logic [31:0]      addr_q, addr_n;
	logic [7:0]       taken_q, taken_n;
	logic             match_q, match_n;
	logic             ignored_q, ignored_n;

	hex_digit_t       hex;
	logic [7:0]       ch;
	logic [7:0]       val;
	logic [8:0]       idx;
	logic [2:0]       aw;
	logic [7:0]       offs;
	logic [POS_W-1:0] min_len;

	assign ch      = stage.character;
	assign hex     = hex_decode(ch);
	assign aw      = {1'b0, type_q} + 3'd1;
	assign val     = (nib_inv_q || hex.invalid) ? 8'd0 : {nib_q, hex.value};
	assign idx     = pos_q[POS_W-1:1] - 9'd1;
	assign offs    = idx[7:0] - {5'd0, aw} - 8'd1;
	// Shortest line that holds every byte up to and including the checksum.
	assign min_len = {1'b0, count_q, 1'b0} + 10'd4;

	always_comb begin
		pos_n     = pos_q;
		type_n    = type_q;
		nib_n     = nib_q;
		nib_inv_n = nib_inv_q;
		count_n   = count_q;
		sum_n     = sum_q;
		addr_n    = addr_q;
		taken_n   = taken_q;
		match_n   = match_q;
		ignored_n = ignored_q;
		res_valid = 1'b0;
		res       = '0;

		if (ch == CHAR_NL) begin
			if (pos_q != '0) begin
				res_valid        = 1'b1;
				res.kind         = KIND_STATUS;
				res.data_length  = taken_q;
				if (ignored_q || type_q == REC_NONE) begin
					res.line_status = STAT_IGNORED;
					res.record_kind = REC_NONE;
				end else begin
					res.record_kind = type_q;
					if (count_q < {5'd0, aw} + 8'd1 || pos_q < min_len) begin
						res.line_status = STAT_MALFORMED;
					end else if (match_q) begin
						res.line_status = STAT_ACCEPTED;
					end else begin
						res.line_status = STAT_BAD_SUM;
					end
				end
				pos_n     = '0;
				type_n    = REC_NONE;
				nib_n     = 4'd0;
				nib_inv_n = 1'b0;
				count_n   = 8'd0;
				sum_n     = 8'd0;
				addr_n    = 32'd0;
				taken_n   = 8'd0;
				match_n   = 1'b0;
				ignored_n = 1'b0;
			end
		end else begin
			if (pos_q != POS_MAX) begin
				pos_n = pos_q + 10'd1;
			end
			if (!ignored_q) begin
				if (pos_q == 10'd0) begin
					if (ch != CHAR_S_UP && ch != CHAR_S_LOW) begin
						ignored_n = 1'b1;
					end
				end else if (pos_q == 10'd1) begin
					if (ch >= CHAR_ONE && ch <= CHAR_THREE) begin
						type_n = ch[1:0];
					end else begin
						ignored_n = 1'b1;
					end
				end else if (!pos_q[0]) begin
					nib_inv_n = hex.invalid;
					nib_n     = hex.value;
				end else if (idx == 9'd0) begin
					count_n = val;
					sum_n   = val;
				end else if (idx > {1'b0, count_q}) begin
					// Characters after the checksum are dropped.
				end else if (idx == {1'b0, count_q}) begin
					match_n = (~sum_q == val);
				end else if (idx <= {6'd0, aw}) begin
					addr_n = {addr_q[23:0], val};
					sum_n  = sum_q + val;
				end else begin
					sum_n           = sum_q + val;
					taken_n         = taken_q + 8'd1;
					res_valid       = 1'b1;
					res.kind        = KIND_DATA;
					res.address     = addr_q + {24'd0, offs};
					res.data_byte   = val;
					res.byte_offset = offs;
					res.record_kind = type_q;
					res.line_status = STAT_ACCEPTED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			type_q    <= REC_NONE;
			nib_q     <= 4'd0;
			nib_inv_q <= 1'b0;
			count_q   <= 8'd0;
			sum_q     <= 8'd0;
			addr_q    <= 32'd0;
			taken_q   <= 8'd0;
			match_q   <= 1'b0;
			ignored_q <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_n;
			type_q    <= type_n;
			nib_q     <= nib_n;
			nib_inv_q <= nib_inv_n;
			count_q   <= count_n;
			sum_q     <= sum_n;
			addr_q    <= addr_n;
			taken_q   <= taken_n;
			match_q   <= match_n;
			ignored_q <= ignored_n;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/srdlp_out_reg.sv
// Result register that holds one word until the consumer takes it.
`default_nettype none
module srdlp_out_reg (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       load,
	input  srdlp_pkg::result_t        res,
	output logic                      free,
	srdlp_result_if.source            results
);
	import srdlp_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign results.valid       = valid_q;
	assign results.kind        = res_q.kind;
	assign results.address     = res_q.address;
	assign results.data_byte   = res_q.data_byte;
	assign results.byte_offset = res_q.byte_offset;
	assign results.record_kind = res_q.record_kind;
	assign results.line_status = res_q.line_status;
	assign results.data_length = res_q.data_length;
endmodule
`default_nettype wire

FILE: rtl/core/srecord_data_line_parser_unit.sv
// Top level of the S-record S1/S2/S3 data line parser.
// Path: an accepted character waits in the input register while the line core forms its
// result combinationally; the result register captures that result once it is free.
// Throughput: one character per cycle while the result register is free; the input register and
// the result register let a new character enter while the previous result waits to be taken.
// Reset: arst_n clears the line state and both valid flags at once; no clearing pass.
`default_nettype none
`include "srecord_data_line_parser_unit_assert.svh"
module srecord_data_line_parser_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	srdlp_char_if.sink                chars,
	srdlp_result_if.source            results
);
	import srdlp_pkg::*;

	char_stage_t stage;
	logic        out_free;
	logic        advance;
	logic        res_valid;
	result_t     res;

	assign advance = stage.valid && out_free;

	srdlp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_char  (chars.character),
		.in_ready (chars.ready),
		.advance  (advance),
		.stage    (stage)
	);

	srdlp_line_core u_line_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	srdlp_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_valid),
		.res     (res),
		.free    (out_free),
		.results (results)
	);

	`SRDLP_ASSERT_IMPLY(a_data_clean, clk, arst_n,
		results.valid && results.kind == KIND_DATA,
		results.line_status == STAT_ACCEPTED && results.data_length == 8'd0)
	`SRDLP_ASSERT_IMPLY(a_ignored_no_kind, clk, arst_n,
		results.valid && results.kind == KIND_STATUS && results.line_status == STAT_IGNORED,
		results.record_kind == REC_NONE)
	`SRDLP_ASSERT_IMPLY(a_status_zero_addr, clk, arst_n,
		results.valid && results.kind == KIND_STATUS,
		results.address == 32'd0 && results.byte_offset == 8'd0)
	`SRDLP_ASSERT_NEXT(a_stall_holds_stage, clk, arst_n,
		stage.valid && !out_free,
		stage.valid && $stable(stage.character))
endmodule
`default_nettype wire
